// ===== rtl/kts_pkg.sv =====
package kts_pkg;

   localparam int unsigned ONE_Q16 = 65536;
   localparam logic [47:0] TWO_PI_Q30 = 48'd6746518852;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [34:0] TWO_PI_Q30_S = 35'sd6746518852;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
   localparam int unsigned DIV_STEPS = 48;
   localparam int unsigned RED_STEPS = 15;

   typedef enum logic [4:0] {
      OP_NONE  = 5'd0,
      OP_LATCH = 5'd1,
      OP_FIRST = 5'd2,
      OP_PRIOR = 5'd3,
      OP_DIV   = 5'd4,
      OP_KSET  = 5'd5,
      OP_RAW   = 5'd6,
      OP_MUL   = 5'd7,
      OP_UPD   = 5'd8,
      OP_VMUL  = 5'd9,
      OP_VUPD  = 5'd10,
      OP_CORR  = 5'd11,
      OP_AINIT = 5'd12,
      OP_RED   = 5'd13,
      OP_FOLD  = 5'd14,
      OP_CORD  = 5'd15,
      OP_OUT   = 5'd16
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [5:0] cnt;
      logic [1:0] ch;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic out_busy;
   } status_type;

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      logic [31:0] r;
      if (v > 36'sd2147483647) r = 32'h7FFF_FFFF;
      else if (v < -36'sd2147483648) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // arctangent of 2^-i in Q2.30
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0: r = 30'd843314857;
         5'd1: r = 30'd497837829;
         5'd2: r = 30'd263043837;
         5'd3: r = 30'd133525159;
         5'd4: r = 30'd67021687;
         5'd5: r = 30'd33543516;
         5'd6: r = 30'd16775851;
         5'd7: r = 30'd8388437;
         5'd8: r = 30'd4194283;
         5'd9: r = 30'd2097149;
         default: r = 30'd1 << (5'd30 - i);
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/kalman_trajectory_smoother.sv =====
// A request passes through a bit-serial gain divider (48 quotient bits), three per-channel
// multiply passes, a 15-step modulo-2pi reduction and one CORDIC rotation per cycle;
// the first frame skips the divider and multiply passes.
// Requests are accepted only when idle, so a new one waits until the last has reached the output register.
// Reset (synchronous, active high) restores first-frame state, unit variance,
// zero trajectories and the default noise registers.
module kalman_trajectory_smoother #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // step_dx [31:0], step_dy [63:32], step_angle [82:64], zero pad
   input  logic [87:0]  req_tdata,
   // found [0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // corr_dx, corr_dy, corr_angle, cos_angle, sin_angle, 32 bits each from bit 0
   output logic [159:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [2:0] ADDR_PROCESS = 3'd0;
   localparam logic [2:0] ADDR_MEASURE = 3'd4;

   logic [19:0]         process_noise_ff;
   logic [19:0]         measure_noise_ff;
   kts_pkg::cmd_type    cmd;
   kts_pkg::status_type status;

   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         process_noise_ff <= 20'd2621;
         measure_noise_ff <= 20'd16384;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == ADDR_PROCESS) process_noise_ff <= csr_pwdata[19:0];
         if (csr_paddr == ADDR_MEASURE) measure_noise_ff <= csr_pwdata[19:0];
      end
   end

   // register reads
   always_comb begin
      case (csr_paddr)
         ADDR_PROCESS: csr_prdata = {12'd0, process_noise_ff};
         ADDR_MEASURE: csr_prdata = {12'd0, measure_noise_ff};
         default:      csr_prdata = '0;
      endcase
   end

   kts_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   kts_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .process_noise(process_noise_ff),
      .measure_noise(measure_noise_ff),
      .found(req_tuser),
      .step_dx(req_tdata[31:0]),
      .step_dy(req_tdata[63:32]),
      .step_angle(req_tdata[82:64]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .corr_dx(rsp_tdata[31:0]),
      .corr_dy(rsp_tdata[63:32]),
      .corr_angle(rsp_tdata[95:64]),
      .cos_angle(rsp_tdata[127:96]),
      .sin_angle(rsp_tdata[159:128])
   );

   a_csr_ready: assert property (@(posedge clock) csr_pready)
      else $error("config port not ready");

endmodule

// ===== rtl/kts_ctrl.sv =====
module kts_ctrl #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  kts_pkg::status_type status,
   output kts_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      S_IDLE  = 16'h0001,
      S_FIRST = 16'h0002,
      S_PRIOR = 16'h0004,
      S_DIV   = 16'h0008,
      S_KSET  = 16'h0010,
      S_RAW   = 16'h0020,
      S_MUL   = 16'h0040,
      S_UPD   = 16'h0080,
      S_VMUL  = 16'h0100,
      S_VUPD  = 16'h0200,
      S_CORR  = 16'h0400,
      S_AINIT = 16'h0800,
      S_RED   = 16'h1000,
      S_FOLD  = 16'h2000,
      S_CORD  = 16'h4000,
      S_OUT   = 16'h8000
   } state_type;

   localparam logic [5:0] DIV_LAST = 6'(kts_pkg::DIV_STEPS - 1);
   localparam logic [5:0] RED_LAST = 6'(kts_pkg::RED_STEPS - 1);
   localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] ch_ff, ch_in;

   assign req_tready = (state_ff == S_IDLE);

   // sequence the filter, reduction and rotation steps
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ch_in = ch_ff;
      cmd.op = kts_pkg::OP_NONE;
      cmd.cnt = cnt_ff;
      cmd.ch = ch_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op = kts_pkg::OP_LATCH;
               state_in = status.first ? S_FIRST : S_PRIOR;
            end
         end
         S_FIRST: begin
            cmd.op = kts_pkg::OP_FIRST;
            state_in = S_CORR;
         end
         S_PRIOR: begin
            cmd.op = kts_pkg::OP_PRIOR;
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = kts_pkg::OP_DIV;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) state_in = S_KSET;
         end
         S_KSET: begin
            cmd.op = kts_pkg::OP_KSET;
            ch_in = '0;
            state_in = S_RAW;
         end
         S_RAW: begin
            cmd.op = kts_pkg::OP_RAW;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.op = kts_pkg::OP_MUL;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op = kts_pkg::OP_UPD;
            ch_in = ch_ff + 2'd1;
            state_in = (ch_ff == 2'd2) ? S_VMUL : S_RAW;
         end
         S_VMUL: begin
            cmd.op = kts_pkg::OP_VMUL;
            state_in = S_VUPD;
         end
         S_VUPD: begin
            cmd.op = kts_pkg::OP_VUPD;
            state_in = S_CORR;
         end
         S_CORR: begin
            cmd.op = kts_pkg::OP_CORR;
            state_in = S_AINIT;
         end
         S_AINIT: begin
            cmd.op = kts_pkg::OP_AINIT;
            cnt_in = '0;
            state_in = S_RED;
         end
         S_RED: begin
            cmd.op = kts_pkg::OP_RED;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == RED_LAST) state_in = S_FOLD;
         end
         S_FOLD: begin
            cmd.op = kts_pkg::OP_FOLD;
            cnt_in = '0;
            state_in = S_CORD;
         end
         S_CORD: begin
            cmd.op = kts_pkg::OP_CORD;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == CORD_LAST) state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the previous result is taken
            if (!status.out_busy) begin
               cmd.op = kts_pkg::OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         ch_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ch_ff <= ch_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted but controller stayed idle");
   a_cord_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CORD) |-> (cnt_ff <= CORD_LAST))
      else $error("cordic counter past last step");
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RAW || state_ff == S_UPD) |-> (ch_ff <= 2'd2))
      else $error("channel index out of range");

endmodule

// ===== rtl/kts_datapath.sv =====
module kts_datapath (
   input  logic                clock,
   input  logic                reset,
   input  kts_pkg::cmd_type    cmd,
   output kts_pkg::status_type status,
   input  logic [19:0]         process_noise,
   input  logic [19:0]         measure_noise,
   input  logic                found,
   input  logic [31:0]         step_dx,
   input  logic [31:0]         step_dy,
   input  logic [18:0]         step_angle,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         corr_dx,
   output logic [31:0]         corr_dy,
   output logic [31:0]         corr_angle,
   output logic [31:0]         cos_angle,
   output logic [31:0]         sin_angle
);

   logic               first_ff;
   logic [31:0]        raw_ff [3];
   logic [31:0]        smooth_ff [3];
   logic [31:0]        last_ff [3];
   logic [31:0]        step_ff [3];
   logic [31:0]        corr_ff [3];
   logic [31:0]        var_ff;
   logic [31:0]        pp_ff;
   logic [33:0]        rem_ff;
   logic [47:0]        quo_ff;
   logic [16:0]        k_ff;
   logic signed [32:0] diff_ff;
   logic signed [50:0] prod_ff;
   logic [47:0]        ang_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic               valid_ff;

   logic [32:0]        pp_sum;
   logic [32:0]        den_w;
   logic [47:0]        num_w;
   logic [5:0]         num_idx;
   logic [33:0]        rem_sh;
   logic [31:0]        raw_new;
   logic [31:0]        in_step [3];
   logic [3:0]         red_sh;
   logic [47:0]        red_sub;
   logic signed [33:0] r_w, r_wrap;
   logic signed [33:0] x_sh, y_sh, x_o, y_o;
   logic [4:0]         ci;
   logic [29:0]        at;

   assign in_step[0] = step_dx;
   assign in_step[1] = step_dy;
   assign in_step[2] = {{13{step_angle[18]}}, step_angle};

   assign pp_sum = {1'b0, var_ff} + {13'd0, process_noise};
   assign den_w = {1'b0, pp_ff} + {13'd0, measure_noise};
   assign num_w = {pp_ff, 16'd0};
   assign num_idx = 6'(kts_pkg::DIV_STEPS - 1) - cmd.cnt;
   assign rem_sh = {rem_ff[32:0], num_w[num_idx]};
   assign raw_new = kts_pkg::sat32(36'(signed'(raw_ff[cmd.ch])) + 36'(signed'(step_ff[cmd.ch])));
   assign red_sh = 4'(kts_pkg::RED_STEPS - 1) - cmd.cnt[3:0];
   assign red_sub = kts_pkg::TWO_PI_Q30 << red_sh;
   assign r_w = ang_ff[33:0];
   assign r_wrap = (r_w > kts_pkg::PI_Q30) ? 34'(35'(r_w) - kts_pkg::TWO_PI_Q30_S) : r_w;
   assign ci = cmd.cnt[4:0];
   assign at = kts_pkg::atan_q30(ci);
   assign x_sh = x_ff >>> ci;
   assign y_sh = y_ff >>> ci;
   assign x_o = flip_ff ? -x_ff : x_ff;
   assign y_o = flip_ff ? -y_ff : y_ff;

   assign status.first = first_ff;
   assign status.out_busy = valid_ff && !rsp_tready;
   assign rsp_tvalid = valid_ff;

   // control flags, variance and trajectory state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         valid_ff <= 1'b0;
         var_ff <= 32'(kts_pkg::ONE_Q16);
         for (int i = 0; i < 3; i++) begin
            raw_ff[i] <= '0;
            smooth_ff[i] <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         if (cmd.op == kts_pkg::OP_OUT) valid_ff <= 1'b1;
         else if (rsp_tready) valid_ff <= 1'b0;
         case (cmd.op)
            kts_pkg::OP_LATCH: begin
               if (found) for (int i = 0; i < 3; i++) last_ff[i] <= in_step[i];
            end
            kts_pkg::OP_FIRST: begin
               first_ff <= 1'b0;
               var_ff <= 32'(kts_pkg::ONE_Q16);
               for (int i = 0; i < 3; i++) begin
                  raw_ff[i] <= step_ff[i];
                  smooth_ff[i] <= '0;
               end
            end
            kts_pkg::OP_RAW: raw_ff[cmd.ch] <= raw_new;
            kts_pkg::OP_UPD: smooth_ff[cmd.ch] <= kts_pkg::sat32(
               36'(signed'(smooth_ff[cmd.ch])) + 36'(prod_ff >>> 16));
            kts_pkg::OP_VUPD: var_ff <= prod_ff[47:16];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         kts_pkg::OP_LATCH: begin
            for (int i = 0; i < 3; i++) step_ff[i] <= found ? in_step[i] : last_ff[i];
         end
         kts_pkg::OP_PRIOR: begin
            pp_ff <= pp_sum[32] ? 32'hFFFF_FFFF : pp_sum[31:0];
            rem_ff <= '0;
            quo_ff <= '0;
         end
         kts_pkg::OP_DIV: begin
            // one quotient bit per cycle
            if (rem_sh >= {1'b0, den_w}) begin
               rem_ff <= rem_sh - {1'b0, den_w};
               quo_ff <= {quo_ff[46:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[46:0], 1'b0};
            end
         end
         kts_pkg::OP_KSET: begin
            if (den_w == '0) k_ff <= '0;
            else if (quo_ff > 48'(kts_pkg::ONE_Q16)) k_ff <= 17'(kts_pkg::ONE_Q16);
            else k_ff <= quo_ff[16:0];
         end
         kts_pkg::OP_RAW: diff_ff <= 33'(signed'(raw_new)) - 33'(signed'(smooth_ff[cmd.ch]));
         kts_pkg::OP_MUL: prod_ff <= signed'({1'b0, k_ff}) * diff_ff;
         kts_pkg::OP_VMUL: prod_ff <= signed'({2'b00,
            49'(17'(kts_pkg::ONE_Q16) - k_ff) * 49'(pp_ff)});
         kts_pkg::OP_CORR: begin
            for (int i = 0; i < 3; i++)
               corr_ff[i] <= kts_pkg::sat32(36'(signed'(step_ff[i]))
                  + 36'(signed'(smooth_ff[i])) - 36'(signed'(raw_ff[i])));
         end
         kts_pkg::OP_AINIT: begin
            // scale to Q2.30, shift negatives into range
            if (corr_ff[2][31])
               ang_ff <= 48'(signed'({corr_ff[2], 14'd0})) + (kts_pkg::TWO_PI_Q30 << 13);
            else
               ang_ff <= {2'b00, corr_ff[2], 14'd0};
         end
         kts_pkg::OP_RED: begin
            if (ang_ff >= red_sub) ang_ff <= ang_ff - red_sub;
         end
         kts_pkg::OP_FOLD: begin
            x_ff <= kts_pkg::GAIN_Q30;
            y_ff <= '0;
            if (r_wrap > kts_pkg::HALF_PI_Q30) begin
               z_ff <= r_wrap - kts_pkg::PI_Q30;
               flip_ff <= 1'b1;
            end else if (r_wrap < -kts_pkg::HALF_PI_Q30) begin
               z_ff <= r_wrap + kts_pkg::PI_Q30;
               flip_ff <= 1'b1;
            end else begin
               z_ff <= r_wrap;
               flip_ff <= 1'b0;
            end
         end
         kts_pkg::OP_CORD: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - signed'({4'd0, at});
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + signed'({4'd0, at});
            end
         end
         kts_pkg::OP_OUT: begin
            corr_dx <= corr_ff[0];
            corr_dy <= corr_ff[1];
            corr_angle <= corr_ff[2];
            cos_angle <= (x_o > kts_pkg::ONE_Q30) ? 32'(kts_pkg::ONE_Q30) :
                         (x_o < -kts_pkg::ONE_Q30) ? 32'(-kts_pkg::ONE_Q30) : x_o[31:0];
            sin_angle <= (y_o > kts_pkg::ONE_Q30) ? 32'(kts_pkg::ONE_Q30) :
                         (y_o < -kts_pkg::ONE_Q30) ? 32'(-kts_pkg::ONE_Q30) : y_o[31:0];
         end
         default: ;
      endcase
   end

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == kts_pkg::OP_MUL) |-> (k_ff <= 17'(kts_pkg::ONE_Q16)))
      else $error("gain above one");
   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == kts_pkg::OP_VUPD) |=> (var_ff <= pp_ff))
      else $error("posterior variance above prior");
   a_red_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == kts_pkg::OP_FOLD) |-> (ang_ff < kts_pkg::TWO_PI_Q30))
      else $error("angle reduction left value out of range");

endmodule

// ===== sim/tb_kalman_trajectory_smoother.sv =====
`timescale 1ns / 100ps

module tb_kalman_trajectory_smoother;

   localparam int STEPS = 24;
   localparam int N_RANDOM = 2000;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [2:0] ADDR_PROCESS_NOISE = 3'd0;
   localparam logic [2:0] ADDR_MEASURE_NOISE = 3'd4;
   localparam longint PI_Q30_L = 64'sd3373259426;
   localparam longint TWO_PI_Q30_L = 64'sd6746518852;
   localparam longint HALF_PI_Q30_L = 64'sd1686629713;
   localparam longint GAIN_Q30_L = 64'sd652032874;
   localparam longint ONE_Q30_L = 64'sd1073741824;

   typedef struct {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] ang;
      logic signed [31:0] cosv;
      logic signed [31:0] sinv;
   } motion_type;

   // Smoothing filter state plus queue of pending corrections
   class smoother_board;
      bit first_frame;
      int raw_traj[3];
      int smooth_traj[3];
      longint unsigned error_var;
      int last_motion[3];
      longint unsigned q_noise;
      longint unsigned r_noise;
      motion_type pending[$];
      int mismatches;

      function new();
         first_frame = 1;
         error_var = 65536;
         q_noise = 2621;
         r_noise = 16384;
         mismatches = 0;
         for (int i = 0; i < 3; i++) begin
            raw_traj[i] = 0;
            smooth_traj[i] = 0;
            last_motion[i] = 0;
         end
      endfunction

      function longint sat(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function void rotate(int ang, output longint c, output longint s);
         longint r, x, y, t;
         bit flip;
         r = longint'(ang) * 16384;
         x = GAIN_Q30_L;
         y = 0;
         flip = 0;
         r = r % TWO_PI_Q30_L;
         if (r < 0) r += TWO_PI_Q30_L;
         if (r > PI_Q30_L) r -= TWO_PI_Q30_L;
         if (r > HALF_PI_Q30_L) begin
            r -= PI_Q30_L;
            flip = 1;
         end else if (r < -HALF_PI_Q30_L) begin
            r += PI_Q30_L;
            flip = 1;
         end
         for (int i = 0; i < STEPS; i++) begin
            if (r >= 0) begin
               t = x - (y >>> i);
               y = y + (x >>> i);
               r -= longint'(kts_pkg::atan_q30(i[4:0]));
            end else begin
               t = x + (y >>> i);
               y = y - (x >>> i);
               r += longint'(kts_pkg::atan_q30(i[4:0]));
            end
            x = t;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         if (x > ONE_Q30_L) x = ONE_Q30_L;
         if (x < -ONE_Q30_L) x = -ONE_Q30_L;
         if (y > ONE_Q30_L) y = ONE_Q30_L;
         if (y < -ONE_Q30_L) y = -ONE_Q30_L;
         c = x;
         s = y;
      endfunction

      // Advance the filter by one frame and queue its correction
      function void note_frame(bit found, int sdx, int sdy, logic signed [18:0] sang);
         int step[3];
         longint corr[3];
         longint unsigned pp, den, k;
         longint d, c, s;
         motion_type m;
         if (found) begin
            step[0] = sdx;
            step[1] = sdy;
            step[2] = int'(sang);
            for (int i = 0; i < 3; i++) last_motion[i] = step[i];
         end else begin
            for (int i = 0; i < 3; i++) step[i] = last_motion[i];
         end
         if (first_frame) begin
            for (int i = 0; i < 3; i++) begin
               raw_traj[i] = step[i];
               smooth_traj[i] = 0;
            end
            error_var = 65536;
            first_frame = 0;
         end else begin
            pp = error_var + q_noise;
            if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
            den = pp + r_noise;
            k = (den != 0) ? ((pp << 16) / den) : 0;
            if (k > 65536) k = 65536;
            for (int i = 0; i < 3; i++) begin
               raw_traj[i] = int'(sat(longint'(raw_traj[i]) + step[i]));
               d = longint'(raw_traj[i]) - smooth_traj[i];
               smooth_traj[i] = int'(sat(longint'(smooth_traj[i]) +
                                         ((longint'(k) * d) >>> 16)));
            end
            error_var = ((65536 - k) * pp) >> 16;
            error_var &= 64'hFFFF_FFFF;
         end
         for (int i = 0; i < 3; i++)
            corr[i] = sat(longint'(step[i]) + smooth_traj[i] - raw_traj[i]);
         rotate(int'(corr[2]), c, s);
         m.dx = corr[0][31:0];
         m.dy = corr[1][31:0];
         m.ang = corr[2][31:0];
         m.cosv = c[31:0];
         m.sinv = s[31:0];
         pending.insert(pending.size(), m);
      endfunction

      // Compare one result with the oldest pending correction
      function void check_result(logic [159:0] data);
         motion_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", data);
            return;
         end
         e = pending.pop_front();
         if (data !== {e.sinv, e.cosv, e.ang, e.dy, e.dx}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h %h %h %h got %h %h %h %h %h",
                  e.dx, e.dy, e.ang, e.cosv, e.sinv, data[31:0], data[63:32],
                  data[95:64], data[127:96], data[159:128]);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [87:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [159:0] rsp_tdata;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   smoother_board board = new();
   int cycles = 0;
   bit hold_off = 0;

   kalman_trajectory_smoother #(.CORDIC_STEPS(STEPS)) i_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver: random stall pattern, long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (hold_off) rsp_tready <= 0;
      else rsp_tready <= ($urandom_range(0, 3) != 0) || cycles[9];
   end

   task automatic write_reg(logic [2:0] addr, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_paddr <= addr;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      if (addr == ADDR_PROCESS_NOISE) board.q_noise = val[19:0];
      else board.r_noise = val[19:0];
   endtask

   task automatic send_frame(bit found, logic [31:0] sdx, logic [31:0] sdy,
                             logic [18:0] sang);
      req_tvalid <= 1;
      req_tuser <= found;
      req_tdata <= {5'd0, sang, sdy, sdx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_frame(found, sdx, sdy, sang);
   endtask

   task automatic idle_gap(int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (130) @(posedge clock);
   endtask

   function automatic logic [18:0] rand_angle(int mode);
      if (mode == 0) return 19'(int'($urandom_range(0, 411774)) - 205887);
      return 19'(int'($urandom_range(0, 2000)) - 1000);
   endfunction

   task automatic random_phase(int n);
      int burst;
      logic [31:0] dx, dy;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: begin
               dx = $urandom;
               dy = $urandom;
            end
            default: begin
               dx = 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
               dy = 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            end
         endcase
         send_frame($urandom_range(0, 4) != 0, dx, dy, rand_angle($urandom_range(0, 1)));
         if (burst <= 0) begin
            burst = $urandom_range(1, 12);
            if ($urandom_range(0, 1)) idle_gap($urandom_range(1, 150));
         end
         burst--;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, first frame with found low, reuse
      send_frame(0, 32'h1234, 32'h5678, 19'h1);
      send_frame(1, 32'h7FFF_FFFF, 32'h8000_0000, 19'sd205887);
      send_frame(1, 32'h7FFF_FFFF, 32'h8000_0000, -19'sd205887);
      send_frame(0, 32'h0, 32'h0, 19'h0);
      send_frame(1, 32'h8000_0000, 32'h7FFF_FFFF, 19'h0);
      send_frame(1, 32'hFFFF_FFFF, 32'h0000_0001, 19'sd102944);
      send_frame(1, 32'h0, 32'h0, -19'sd102944);
      send_frame(1, 32'h0001_0000, 32'hFFFF_0000, 19'sd1);
      send_frame(0, 32'h0, 32'h0, 19'h0);
      drain();

      // Extreme noise settings
      write_reg(ADDR_PROCESS_NOISE, 32'h000F_FFFF);
      write_reg(ADDR_MEASURE_NOISE, 32'h0000_0001);
      random_phase(15);
      drain();
      write_reg(ADDR_PROCESS_NOISE, 32'h0000_0001);
      write_reg(ADDR_MEASURE_NOISE, 32'h000F_FFFF);
      random_phase(15);
      drain();

      // Back-pressure: hold the receiver while frames keep arriving
      hold_off = 1;
      fork
         begin
            repeat (2000) @(posedge clock);
            hold_off = 0;
         end
         random_phase(10);
      join
      drain();

      // Random settings
      for (int p = 0; p < 8; p++) begin
         write_reg(ADDR_PROCESS_NOISE, $urandom_range(1, 20'hFFFFF));
         write_reg(ADDR_MEASURE_NOISE, $urandom_range(1, 20'hFFFFF));
         random_phase(N_RANDOM / 8);
         drain();
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
